@@ sv/bphq_pkg.sv @@
// Shared types and constants for the button press/hold qualifier.
package bphq_pkg;

  localparam int unsigned DivW  = 16;
  localparam int unsigned CntW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [2:0]      LevelsReleased = 3'b111;

  // Reset values of the configuration registers.
  localparam logic [DivW-1:0] PollDividerRst      = 16'd100;
  localparam logic [CntW-1:0] OffHoldPollsRst     = 8'd20;
  localparam logic [CntW-1:0] StartHoldPollsRst   = 8'd10;
  localparam logic [CntW-1:0] GearHoldPollsRst    = 8'd10;
  localparam logic [CntW-1:0] GearLockoutTicksRst = 8'd20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLL_DIVIDER       = 3'd0,
    CFG_OFF_HOLD_POLLS     = 3'd1,
    CFG_START_HOLD_POLLS   = 3'd2,
    CFG_GEAR_HOLD_POLLS    = 3'd3,
    CFG_GEAR_LOCKOUT_TICKS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic off_level;
    logic start_level;
    logic gear_level;
  } bphq_in_t;

  typedef struct packed {
    logic off_tap;
    logic off_long;
    logic start_long;
    logic gear_tap;
    logic gear_long;
  } bphq_out_t;

  // Hold-counter status of a latching button.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            latched;
  } bphq_btn_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

endpackage

@@ sv/bphq_latch_btn.sv @@
// Hold counter and latch for one latching button (start or gear).
module bphq_latch_btn import bphq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            poll_i,
  input  logic            pressed_i,
  input  logic [CntW-1:0] limit_i,
  output bphq_btn_t       status_o,
  output logic            hold_o
);

  logic [CntW-1:0] count_q, count_d, count_inc;
  logic            latched_q, latched_d;

  assign count_inc = sat_inc(count_q);

  always_comb begin
    count_d   = count_q;
    latched_d = latched_q;
    hold_o    = 1'b0;
    if (poll_i) begin
      if (!pressed_i) begin
        count_d   = '0;
        latched_d = 1'b0;
      end else if (!latched_q) begin
        count_d = count_inc;
        if (count_inc >= limit_i) begin
          latched_d = 1'b1;
          hold_o    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      latched_q <= 1'b0;
    end else if (step_i) begin
      count_q   <= count_d;
      latched_q <= latched_d;
    end
  end

  assign status_o.count   = count_q;
  assign status_o.latched = latched_q;

endmodule

@@ sv/button_press_hold_qualifier.sv @@
// Top level of the button press/hold qualifier for off, start and gear buttons.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): one word per fine tick,
//   carrying the raw active-low levels of the off, start and gear buttons.
//   Output channel (out_valid_o/out_ready_i/out_data_o): exactly one result
//   word per input word, in order, holding the press and hold flags.
//   Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always
//   ready; writes the poll divider, hold limits and gear lockout. Unknown
//   indexes are dropped. Write only while no result is outstanding.
// Timing:
//   The result is registered: it is loaded into the output register on the
//   edge that takes the word. One word per cycle is sustained while
//   out_ready_i stays high; the rate is set by the single output register,
//   which refills on the same edge it drains.
// Reset:
//   Counters, latches and the lockout clear, the previous levels read as all
//   released, the registers take their defaults and the output is empty.
// Stall:
//   While a result waits and out_ready_i is low, in_ready_o drops and all tick
//   state holds; nothing is lost or repeated.
module button_press_hold_qualifier import bphq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bphq_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bphq_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [DivW-1:0] poll_divider_q;
  logic [CntW-1:0] off_hold_polls_q, start_hold_polls_q;
  logic [CntW-1:0] gear_hold_polls_q, gear_lockout_ticks_q;

  // Tick state.
  logic [DivW-1:0] prescaler_q, prescaler_d;
  logic [DivW:0]   prescaler_next;
  logic [CntW-1:0] off_count_q, off_count_d, off_count_inc;
  logic [CntW-1:0] lockout_q, lockout_d;
  logic [2:0]      prev_levels_q;
  logic [2:0]      levels, rising;

  logic      out_valid_q;
  bphq_out_t out_data_q, result;

  logic      step, poll;
  logic      start_long, gear_long;
  bphq_btn_t start_status, gear_status;

  assign cfg_ready_o = 1'b1;

  // Take a new word whenever the output register is empty or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  // Bit 0 off, bit 1 start, bit 2 gear; high means released.
  assign levels = {in_data_i.gear_level, in_data_i.start_level, in_data_i.off_level};
  assign rising = levels & ~prev_levels_q;

  // Poll when the incremented prescaler reaches the divider.
  assign prescaler_next = {1'b0, prescaler_q} + 1'b1;
  assign poll           = prescaler_next >= {1'b0, poll_divider_q};
  assign prescaler_d    = poll ? '0 : prescaler_next[DivW-1:0];

  assign off_count_inc = sat_inc(off_count_q);

  always_comb begin
    result      = '0;
    off_count_d = off_count_q;
    lockout_d   = lockout_q;

    // Release edges use the counts from before this tick's poll.
    result.off_tap = rising[0] && (off_count_q < off_hold_polls_q);
    if (rising[2] && !gear_status.latched && (gear_status.count < gear_hold_polls_q)
        && (lockout_q == '0)) begin
      result.gear_tap = 1'b1;
      lockout_d       = gear_lockout_ticks_q;
    end else if (lockout_q != '0) begin
      lockout_d = lockout_q - 1'b1;
    end

    // Off reports a hold on every poll at or beyond its limit.
    if (poll) begin
      if (!levels[0]) begin
        off_count_d     = off_count_inc;
        result.off_long = off_count_inc >= off_hold_polls_q;
      end else begin
        off_count_d = '0;
      end
    end

    result.start_long = start_long;
    result.gear_long  = gear_long;
  end

  bphq_latch_btn u_start (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .poll_i    (poll),
    .pressed_i (!levels[1]),
    .limit_i   (start_hold_polls_q),
    .status_o  (start_status),
    .hold_o    (start_long)
  );

  bphq_latch_btn u_gear (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .poll_i    (poll),
    .pressed_i (!levels[2]),
    .limit_i   (gear_hold_polls_q),
    .status_o  (gear_status),
    .hold_o    (gear_long)
  );

  // Advance tick state on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescaler_q   <= '0;
      off_count_q   <= '0;
      lockout_q     <= '0;
      prev_levels_q <= LevelsReleased;
    end else if (step) begin
      prescaler_q   <= prescaler_d;
      off_count_q   <= off_count_d;
      lockout_q     <= lockout_d;
      prev_levels_q <= levels;
    end
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_divider_q       <= PollDividerRst;
      off_hold_polls_q     <= OffHoldPollsRst;
      start_hold_polls_q   <= StartHoldPollsRst;
      gear_hold_polls_q    <= GearHoldPollsRst;
      gear_lockout_ticks_q <= GearLockoutTicksRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_POLL_DIVIDER:       poll_divider_q       <= cfg_data_i[DivW-1:0];
        CFG_OFF_HOLD_POLLS:     off_hold_polls_q     <= cfg_data_i[CntW-1:0];
        CFG_START_HOLD_POLLS:   start_hold_polls_q   <= cfg_data_i[CntW-1:0];
        CFG_GEAR_HOLD_POLLS:    gear_hold_polls_q    <= cfg_data_i[CntW-1:0];
        CFG_GEAR_LOCKOUT_TICKS: gear_lockout_ticks_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Output register: load on accept, drop valid when taken with nothing new.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
